### rtl/dil_pkg.sv
package dil_pkg;

   // Field and register widths
   localparam int CH_W  = 8;
   localparam int PIX_W = 3 * CH_W;
   localparam int FW_W  = 11;
   localparam int FH_W  = 13;
   localparam int CC_W  = 2;
   localparam int PC_W  = 3;
   localparam int TOT_W = FW_W + FH_W;

   // Default build sizes
   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_PASSES_DEF = 4;

   // Register reset values
   localparam logic [FW_W-1:0] FRAME_WIDTH_RST   = 11'd1024;
   localparam logic [FH_W-1:0] FRAME_HEIGHT_RST  = 13'd768;
   localparam logic [CC_W-1:0] CHANNEL_COUNT_RST = 2'd3;
   localparam logic [PC_W-1:0] PASS_COUNT_RST    = 3'd1;

   // Channel count that dilates every channel
   localparam logic [CC_W-1:0] ALL_CHANNELS = 2'd3;

   typedef enum logic [1:0] {
      REG_FRAME_WIDTH,
      REG_FRAME_HEIGHT,
      REG_CHANNEL_COUNT,
      REG_PASS_COUNT
   } reg_index_type;

   typedef logic [PIX_W-1:0] pixel_type;

   // One item on the stage chain: pix low marks a flush
   typedef struct packed {
      logic      valid;
      logic      pix;
      pixel_type data;
   } token_type;

   // Frame settings as seen by a stage (sizes already saturated)
   typedef struct packed {
      logic [FW_W-1:0] width;
      logic [FH_W-1:0] height;
      logic            all_chan;
   } frame_cfg_type;

   // Per-channel maximum of two pixels
   function automatic pixel_type pix_max(pixel_type a, pixel_type b);
      pixel_type r;
      r = '0;
      for (int i = 0; i < 3; i++) begin
         r[i*CH_W +: CH_W] = (a[i*CH_W +: CH_W] > b[i*CH_W +: CH_W]) ?
                             a[i*CH_W +: CH_W] : b[i*CH_W +: CH_W];
      end
      return r;
   endfunction

endpackage

### rtl/dil_stage.sv
module dil_stage #(
   parameter int MAX_WIDTH = dil_pkg::MAX_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   stage_on,
   input  dil_pkg::frame_cfg_type cfg,
   input  dil_pkg::token_type     in_tok,
   output dil_pkg::token_type     out_tok
);

   localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int CXW = (CW + 1 > dil_pkg::FW_W) ? CW + 1 : dil_pkg::FW_W;
   localparam int RW  = dil_pkg::FH_W + 1;
   localparam int PW  = dil_pkg::PIX_W;
   localparam int CHW = dil_pkg::CH_W;

   // Input position of this stage
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;

   logic [CXW-1:0] width_x, col_x, col_nx;
   logic [RW-1:0]  height_x, row_adj;
   logic [CW-1:0]  col_adj;
   logic           col_wrap, drain, take, emit, col_zero;
   dil_pkg::pixel_type v;

   // Phase one registers
   logic               a_valid_ff, a_take_ff, byp_ff;
   logic               a_emit_ff, a_zero_ff, a_up0_ff, a_up1_ff;
   dil_pkg::pixel_type a_v_ff;
   logic [CW-1:0]      a_col_ff;
   logic [2*PW-1:0]    rd_ff, byp_data_ff;

   // Two line stores per word: upper half is the older row
   logic [2*PW-1:0] line_mem [MAX_WIDTH];

   // Phase two
   logic [2*PW-1:0]    line_word, wr_data;
   dil_pkg::pixel_type up0, up1, colmax, win_max, res, res_sel;
   dil_pkg::pixel_type win0_ff, win1_ff, center_ff;

   logic               out_valid_ff, out_pix_ff;
   dil_pkg::pixel_type out_data_ff;

   // Wrap the position, decide whether this item is processed
   always_comb begin
      width_x  = CXW'(cfg.width);
      height_x = RW'(cfg.height);
      col_x    = CXW'(col_ff);
      col_wrap = col_x >= width_x;
      col_adj  = col_wrap ? '0 : col_ff;
      row_adj  = col_wrap ? row_ff + RW'(1) : row_ff;
      drain    = row_adj >= height_x;
      take     = stage_on && in_tok.valid && (in_tok.pix || drain);
      v        = drain ? '0 : in_tok.data;
      col_zero = (col_adj == '0);
      emit     = col_zero ?
                 ((row_adj >= RW'(2)) && (row_adj <= height_x + RW'(1))) :
                 ((row_adj >= RW'(1)) && (row_adj <= height_x));
      col_nx   = CXW'(col_adj) + CXW'(1);
   end

   // Advance the position
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (take) begin
         priority if (row_adj > height_x) begin
            col_in = '0;
            row_in = '0;
         end else if (col_nx >= width_x) begin
            col_in = '0;
            row_in = row_adj + RW'(1);
         end else begin
            col_in = col_nx[CW-1:0];
            row_in = row_adj;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (advance) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Phase one control
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         a_take_ff  <= 1'b0;
         byp_ff     <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= stage_on && in_tok.valid;
         a_take_ff  <= take;
         byp_ff     <= a_take_ff && (a_col_ff == col_adj);
      end
   end

   // Phase one payload
   always_ff @(posedge clock) begin
      if (advance) begin
         a_emit_ff   <= emit;
         a_zero_ff   <= col_zero;
         a_up0_ff    <= row_adj >= RW'(1);
         a_up1_ff    <= row_adj >= RW'(2);
         a_v_ff      <= v;
         a_col_ff    <= col_adj;
         byp_data_ff <= wr_data;
      end
   end

   // Line store: read at the new column, write back the older item
   always_ff @(posedge clock) begin
      if (advance && take) begin
         rd_ff <= line_mem[col_adj];
      end
      if (advance && a_take_ff) begin
         line_mem[a_col_ff] <= wr_data;
      end
   end

   // Column maximum and window result
   always_comb begin
      line_word = byp_ff ? byp_data_ff : rd_ff;
      wr_data   = {line_word[PW-1:0], a_v_ff};
      up1       = a_up1_ff ? line_word[2*PW-1:PW] : '0;
      up0       = a_up0_ff ? line_word[PW-1:0] : '0;
      colmax    = dil_pkg::pix_max(dil_pkg::pix_max(up1, up0), a_v_ff);
      win_max   = dil_pkg::pix_max(win0_ff, win1_ff);
      res       = a_zero_ff ? win_max : dil_pkg::pix_max(win_max, colmax);
      res_sel   = cfg.all_chan ? res : {center_ff[PW-1:CHW], res[CHW-1:0]};
   end

   // Window and center hold
   always_ff @(posedge clock) begin
      if (reset) begin
         win0_ff <= '0;
         win1_ff <= '0;
      end else if (advance && a_take_ff) begin
         win0_ff <= a_zero_ff ? '0 : win1_ff;
         win1_ff <= colmax;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && a_take_ff) begin
         center_ff <= line_word[PW-1:0];
      end
   end

   // Stage output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         out_pix_ff   <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= a_valid_ff;
         out_pix_ff   <= a_take_ff && a_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= res_sel;
      end
   end

   assign out_tok = '{valid: out_valid_ff, pix: out_pix_ff, data: out_data_ff};

endmodule

### rtl/dilate_3x3_max_filter.sv
// 3x3 grayscale dilation over a raster pixel stream, repeated in a chain of stages.
// req_ carries one transaction per pixel (three 8-bit channels) or, with tuser high,
// a flush transaction that carries no pixel. rsp_ returns dilated pixels, tlast high
// on the final pixel of a frame. After a frame the host sends
// pass_count*(frame_width+1) flush transactions to drain the chain.
// Throughput: one transaction per cycle while rsp_ is not stalled, set by the single read
// and single write port of each stage's line store. From req_ to rsp_ each active stage
// registers an item in its phase one and output registers, then the result register; in
// items, each stage delays a pixel by frame_width+1 transactions.
// Configuration goes through the csr_ APB port: frame_width at 0x0, frame_height at
// 0x4, channel_count at 0x8, pass_count at 0xC; write only while the block is idle.
// Reset clears positions, windows, the pixel count and loads the default settings;
// line stores are not cleared and need no clearing pass.
// When rsp_tready is low with a result waiting, the whole chain holds and req_tready
// drops; any empty result register lets the chain move on.
module dilate_3x3_max_filter #(
   parameter int MAX_WIDTH  = dil_pkg::MAX_WIDTH_DEF,
   parameter int MAX_PASSES = dil_pkg::MAX_PASSES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // input pixels
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // chan0_in [7:0], chan1_in [15:8], chan2_in [23:16]
   input  logic        req_tuser,   // flush [0]
   // results
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // chan0_out [7:0], chan1_out [15:8], chan2_out [23:16]
   output logic        rsp_tlast,
   // configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int PNW = $clog2(MAX_PASSES + 1);
   localparam int NXW = (PNW > dil_pkg::PC_W) ? PNW : dil_pkg::PC_W;
   localparam int WMW = $clog2(MAX_WIDTH + 1);
   localparam int WXW = (WMW > dil_pkg::FW_W) ? WMW : dil_pkg::FW_W;
   localparam int TW  = dil_pkg::TOT_W;

   // Configuration registers
   logic [dil_pkg::FW_W-1:0] frame_width_ff;
   logic [dil_pkg::FH_W-1:0] frame_height_ff;
   logic [dil_pkg::CC_W-1:0] channel_count_ff;
   logic [dil_pkg::PC_W-1:0] pass_count_ff;

   logic                   csr_write;
   dil_pkg::reg_index_type csr_index;

   logic [WXW-1:0]           width_x;
   logic [dil_pkg::FW_W-1:0] width_eff;
   logic [dil_pkg::FH_W-1:0] height_eff;
   logic [NXW-1:0]           pass_x;
   logic [PNW-1:0]           pass_num;
   dil_pkg::frame_cfg_type   cfg;

   logic               advance;
   dil_pkg::token_type tok [MAX_PASSES + 1];
   dil_pkg::token_type fin_tok;

   logic [TW-1:0]      total, frame_cnt_ff, frame_cnt_in, cnt_inc;
   logic               frame_done, load_pix;
   logic               rsp_valid_ff, rsp_last_ff;
   dil_pkg::pixel_type rsp_data_ff;

   // Register writes
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = dil_pkg::reg_index_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff   <= dil_pkg::FRAME_WIDTH_RST;
         frame_height_ff  <= dil_pkg::FRAME_HEIGHT_RST;
         channel_count_ff <= dil_pkg::CHANNEL_COUNT_RST;
         pass_count_ff    <= dil_pkg::PASS_COUNT_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            dil_pkg::REG_FRAME_WIDTH:   frame_width_ff   <= csr_pwdata[dil_pkg::FW_W-1:0];
            dil_pkg::REG_FRAME_HEIGHT:  frame_height_ff  <= csr_pwdata[dil_pkg::FH_W-1:0];
            dil_pkg::REG_CHANNEL_COUNT: channel_count_ff <= csr_pwdata[dil_pkg::CC_W-1:0];
            dil_pkg::REG_PASS_COUNT:    pass_count_ff    <= csr_pwdata[dil_pkg::PC_W-1:0];
         endcase
      end
   end

   // Register reads
   always_comb begin
      unique case (csr_index)
         dil_pkg::REG_FRAME_WIDTH:   csr_prdata = 32'(frame_width_ff);
         dil_pkg::REG_FRAME_HEIGHT:  csr_prdata = 32'(frame_height_ff);
         dil_pkg::REG_CHANNEL_COUNT: csr_prdata = 32'(channel_count_ff);
         dil_pkg::REG_PASS_COUNT:    csr_prdata = 32'(pass_count_ff);
      endcase
   end

   // Saturate sizes and pass count
   always_comb begin
      width_x = WXW'(frame_width_ff);
      if (frame_width_ff == '0) begin
         width_eff = dil_pkg::FW_W'(1);
      end else if (width_x > WXW'(MAX_WIDTH)) begin
         width_eff = dil_pkg::FW_W'(MAX_WIDTH);
      end else begin
         width_eff = frame_width_ff;
      end
      height_eff = (frame_height_ff == '0) ? dil_pkg::FH_W'(1) : frame_height_ff;
      pass_x     = NXW'(pass_count_ff);
      pass_num   = (pass_x > NXW'(MAX_PASSES)) ? PNW'(MAX_PASSES) : pass_x[PNW-1:0];
      cfg        = '{width: width_eff, height: height_eff,
                     all_chan: (channel_count_ff == dil_pkg::ALL_CHANNELS)};
   end

   // The chain moves whenever the result register is free or being taken
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;

   assign tok[0] = '{valid: req_tvalid, pix: !req_tuser, data: req_tdata};

   for (genvar s = 0; s < MAX_PASSES; s++) begin : g_stage
      dil_stage #(
         .MAX_WIDTH (MAX_WIDTH)
      ) u_stage (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .stage_on (pass_num > PNW'(s)),
         .cfg      (cfg),
         .in_tok   (tok[s]),
         .out_tok  (tok[s+1])
      );
   end

   // Take the output of the last active stage
   assign fin_tok = tok[pass_num];

   // Count delivered pixels to find the frame end
   always_comb begin
      total        = TW'(width_eff) * TW'(height_eff);
      cnt_inc      = frame_cnt_ff + TW'(1);
      frame_done   = cnt_inc >= total;
      load_pix     = advance && fin_tok.valid && fin_tok.pix;
      frame_cnt_in = frame_cnt_ff;
      if (load_pix) begin
         frame_cnt_in = frame_done ? '0 : cnt_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_cnt_ff <= '0;
      end else begin
         frame_cnt_ff <= frame_cnt_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= fin_tok.valid && fin_tok.pix;
      end
   end

   always_ff @(posedge clock) begin
      if (load_pix) begin
         rsp_data_ff <= fin_tok.data;
         rsp_last_ff <= frame_done;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // A frame-ending pixel restarts the count and carries tlast
   a_frame_end: assert property (@(posedge clock) disable iff (reset)
      load_pix && frame_done |=> rsp_tlast && (frame_cnt_ff == '0))
      else $error("frame end not marked or count not restarted");

   // With no active stage a pixel reaches the result register at once
   a_bypass: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !req_tuser && (pass_num == '0) |=> rsp_tvalid)
      else $error("bypassed pixel did not reach the result register");

   // A stalled result freezes the pixel count
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(frame_cnt_ff))
      else $error("pixel count moved during a stall");

endmodule
